// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the scanner RTL; empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked every cycle outside reset
`define AST_HOLDS(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition this cycle implies a consequence on the next cycle
`define AST_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AST_HOLDS(name, clk, rst_n, prop, msg)
`define AST_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/wbps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

	// parameter defaults
	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_LEN_W  = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WILD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FIND_ALL = 3'd5;

	// per-cycle control handed to every window cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// pattern byte that one cell compares against
	typedef struct packed {
		logic       active;
		logic       wild;
		logic [7:0] data;
	} cell_pat_t;

endpackage

// ----- rtl/wbps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds an earlier image byte, passes it on, compares it
// ----------------------------------------------------------------------------
module wbps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wbps_pkg::cell_ctl_t ctl,
	input  logic [7:0]          din,
	input  wbps_pkg::cell_pat_t pat,
	output logic [7:0]          dout,
	output logic                ok
);
	import wbps_pkg::*;

	logic [7:0] data_q;

	// shift in from the neighbor, clear at end of image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= 8'h00;
		end else if (ctl.clear) begin
			data_q <= 8'h00;
		end else if (ctl.shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

	// unused cells and wildcards always agree
	assign ok = !pat.active || pat.wild || (pat.data == data_q);

endmodule

// ----- rtl/wildcard_byte_pattern_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streaming scan of a memory image for a wildcard byte pattern
// ----------------------------------------------------------------------------
// Takes one image byte per cycle on the slave side and keeps the previous
// MAX_PATTERN-1 bytes in a row of shifting compare cells; the current byte and
// all cells are checked against the pattern in the cycle the byte is taken, so
// the scanner sustains one byte per clock unless the output stalls, and a
// result word appears on the master side in the cycle after the byte that caused
// it. A result word goes out only for a reported match or for the last byte of
// an image (tlast), and tuser marks whether tdata holds a match offset (start
// plus cursor offset); the single output register stalls input only while a
// result waits and m_tready is low. Configuration writes must be made while no
// image is in flight; the image state clears itself after each last byte.
`include "assert_macros.svh"

module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_wr_en,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// image bytes
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic                            s_tlast,   // end_of_image
	// results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // match_offset
	output logic                            m_tuser,   // match_valid
	output logic                            m_tlast    // scan_done
);
	import wbps_pkg::*;

	localparam int NCELL  = MAX_PATTERN - 1;
	localparam int CELL_W = (NCELL > 0) ? NCELL : 1;
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CMP_W  = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
	localparam logic [CMP_W-1:0] MAXP = CMP_W'(MAX_PATTERN);

	// configuration registers
	logic [63:0]          pat_low_q;
	logic [63:0]          pat_high_q;
	logic [15:0]          wild_q;
	logic [CFG_LEN_W-1:0] length_q;
	logic [CFG_LEN_W-1:0] cursor_q;
	logic                 find_all_q;

	// image state
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   first_found_q;

	// output register
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	logic                   s_acc;
	logic [7:0]             pat_byte [MAX_PATTERN];
	logic                   pat_wild [MAX_PATTERN];
	logic [CMP_W-1:0]       len_raw;
	logic [LEN_W-1:0]       len_eff;
	logic [LEN_W-1:0]       len_m1;
	logic                   len_zero;
	logic                   fits;
	logic                   cur_ok;
	logic [CELL_W-1:0]      cell_ok;
	logic                   hit;
	logic                   report;
	logic                   produce;
	logic [OFFSET_BITS-1:0] delta;
	logic [OFFSET_BITS-1:0] offset;
	logic [OFFSET_BITS+31:0] offset_ext;
	cell_ctl_t              ctl;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wild_q     <= '0;
			length_q   <= CFG_LEN_W'(1);
			cursor_q   <= '0;
			find_all_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PAT_LOW:  pat_low_q  <= cfg_wdata;
				CFG_PAT_HIGH: pat_high_q <= cfg_wdata;
				CFG_WILD:     wild_q     <= cfg_wdata[15:0];
				CFG_LENGTH:   length_q   <= cfg_wdata[CFG_LEN_W-1:0];
				CFG_CURSOR:   cursor_q   <= cfg_wdata[CFG_LEN_W-1:0];
				CFG_FIND_ALL: find_all_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// pattern bytes as an array; bytes past the sixteenth are zero, never wild
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
		if (k < 8) begin : g_low
			assign pat_byte[k] = pat_low_q[8*k +: 8];
			assign pat_wild[k] = wild_q[k];
		end else if (k < 16) begin : g_high
			assign pat_byte[k] = pat_high_q[8*(k-8) +: 8];
			assign pat_wild[k] = wild_q[k];
		end else begin : g_none
			assign pat_byte[k] = 8'h00;
			assign pat_wild[k] = 1'b0;
		end
	end

	// effective length, capped at the cell count plus one
	assign len_raw  = CMP_W'(length_q);
	assign len_eff  = LEN_W'((len_raw > MAXP) ? MAXP : len_raw);
	assign len_zero = (len_eff == '0);
	assign len_m1   = len_eff - LEN_W'(1);

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign ctl.shift = s_acc;
	assign ctl.clear = s_acc && s_tlast;

	// newest byte against the last pattern byte
	assign cur_ok = pat_wild[len_m1[IDX_W-1:0]] || (pat_byte[len_m1[IDX_W-1:0]] == s_tdata);

	// row of window cells, cell 0 holds the newest earlier byte
	if (NCELL > 0) begin : g_row
		logic [7:0] link [NCELL+1];
		assign link[0] = s_tdata;
		for (genvar j = 0; j < NCELL; j++) begin : g_cell
			localparam logic [LEN_W:0] J2 = (LEN_W+1)'(j + 2);
			logic [LEN_W:0] diff;
			cell_pat_t      cp;
			assign diff      = {1'b0, len_eff} - J2;
			assign cp.active = ({1'b0, len_eff} >= J2);
			assign cp.wild   = pat_wild[diff[IDX_W-1:0]];
			assign cp.data   = pat_byte[diff[IDX_W-1:0]];
			wbps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.din    (link[j]),
				.pat    (cp),
				.dout   (link[j+1]),
				.ok     (cell_ok[j])
			);
		end
	end else begin : g_no_row
		assign cell_ok = 1'b1;
	end

	// match decision and offset
	assign fits   = pos_q >= OFFSET_BITS'(len_m1);
	assign hit    = len_zero || (fits && cur_ok && (&cell_ok));
	assign report = hit && (find_all_q || !first_found_q);
	assign produce = report || s_tlast;
	assign delta  = OFFSET_BITS'(cursor_q) - (len_zero ? '0 : OFFSET_BITS'(len_m1));
	assign offset = pos_q + delta;
	assign offset_ext = {32'h0, offset};

	// position count and first-match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			first_found_q <= 1'b0;
		end else if (s_acc) begin
			if (s_tlast) begin
				pos_q         <= '0;
				first_found_q <= 1'b0;
			end else begin
				pos_q <= pos_q + OFFSET_BITS'(1);
				if (report && !find_all_q) begin
					first_found_q <= 1'b1;
				end
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_acc) begin
			m_tvalid_q <= produce;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && produce) begin
			m_tdata_q <= report ? offset_ext[31:0] : 32'h0;
			m_tuser_q <= report;
			m_tlast_q <= s_tlast;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// checks
	`AST_NEXT(a_pos_clear, clk, arst_n, s_acc && s_tlast, pos_q == '0, "position not cleared after last byte")
	`AST_NEXT(a_first_set, clk, arst_n, s_acc && !s_tlast && report && !find_all_q, first_found_q, "first match not recorded")
	`AST_HOLDS(a_word_kind, clk, arst_n, !m_tvalid || m_tuser || m_tlast, "result word with neither match nor done")
	`AST_HOLDS(a_nomatch_zero, clk, arst_n, !m_tvalid || m_tuser || (m_tdata == 32'h0), "done word carries nonzero offset")

endmodule
